FILE: hdl/fid_pkg.sv
// fid_pkg: widths, phase codes, register indexes and reset values of the fall impact detector
// no dependencies; used by fall_impact_detector, fid_checker and the testbench
package fid_pkg;

    // field widths
    localparam int ACCEL_W   = 16;
    localparam int ANGLE_W   = 15;
    localparam int MAG_W     = 32;
    localparam int CHANGE_W  = 16;
    localparam int EVT_W     = 40;
    localparam int THR_W     = 15;
    localparam int THR_SQ_W  = 2 * THR_W;
    localparam int WAIT_W    = 16;

    // uptime counter width, any value from 16 to 64
    localparam int TIME_WIDTH = 40;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMPACT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMMOBILE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL   = 2'd3;

    // register reset values
    localparam logic [THR_W-1:0]    IMPACT_RST   = 15'd5120;
    localparam logic [CHANGE_W-1:0] ANGLE_RST    = 16'd2880;
    localparam logic [WAIT_W-1:0]   IMMOBILE_RST = 16'd1500;
    localparam logic [THR_W-1:0]    STILL_RST    = 15'd512;

    localparam logic [THR_SQ_W-1:0] IMPACT_SQ_RST =
        THR_SQ_W'({15'd0, IMPACT_RST} * {15'd0, IMPACT_RST});
    localparam logic [THR_SQ_W-1:0] STILL_SQ_RST =
        THR_SQ_W'({15'd0, STILL_RST} * {15'd0, STILL_RST});

    // word kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // detector phase; code 3 is unused and behaves as idle
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_CHECK = 2'd2;

    // largest possible squared magnitude and summed angle change
    localparam logic [MAG_W-1:0]    MAG_MAX    = 32'hC000_0000;
    localparam logic [CHANGE_W-1:0] CHANGE_MAX = 16'd65534;

endpackage

FILE: hdl/fall_impact_detector.sv
// fall_impact_detector: impact, tumble and stillness fall detector, top level
// depends on fid_pkg
//
// The block takes one word per clock on its s_ channel: either an IMU sample (kind 0) or a
// one-millisecond tick (kind 1). Ticks drive a free-running uptime counter. A sample whose
// squared acceleration magnitude reaches impact_threshold squared and whose summed pitch and
// roll change reaches angle_threshold starts a wait of immobile_ms ticks, during which samples
// are dropped; the first sample after the wait is checked against still_threshold squared and
// gives one result word: the verdict, the uptime and the held impact values. Every word is
// taken into an input register and decided by one pass of logic (three 16x16 squarers, an
// adder and the compares) as it moves on into the result register; the sustained rate is
// one word per clock while results are taken. While a result waits on m_ready the
// input register still takes one word; s_ready then drops until the result leaves, ticks
// included. Configuration writes on cfg_wr_en take effect at once and are meant for idle
// periods only; the impact and still thresholds are kept squared.
module fall_impact_detector (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration write port
    input  logic                                    cfg_wr_en,
    input  logic [fid_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [fid_pkg::CFG_DATA_W-1:0]          cfg_wr_data,
    // input words
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_kind,
    input  logic signed [fid_pkg::ACCEL_W-1:0]      s_accel_x,
    input  logic signed [fid_pkg::ACCEL_W-1:0]      s_accel_y,
    input  logic signed [fid_pkg::ACCEL_W-1:0]      s_accel_z,
    input  logic signed [fid_pkg::ANGLE_W-1:0]      s_pitch_angle,
    input  logic signed [fid_pkg::ANGLE_W-1:0]      s_roll_angle,
    // result words
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_fall_confirmed,
    output logic [fid_pkg::EVT_W-1:0]               m_event_time_ms,
    output logic [fid_pkg::MAG_W-1:0]               m_impact_magnitude_sq,
    output logic [fid_pkg::CHANGE_W-1:0]            m_orient_delta
);

    // ---------------------------------------------------------------- configuration
    // thresholds compared against magnitudes are stored squared, squared once at write time
    logic [fid_pkg::THR_SQ_W-1:0]  impact_sq_reg;
    logic [fid_pkg::CHANGE_W-1:0]  angle_thr_reg;
    logic [fid_pkg::WAIT_W-1:0]    immobile_reg;
    logic [fid_pkg::THR_SQ_W-1:0]  still_sq_reg;
    logic [fid_pkg::THR_W-1:0]     cfg_thr;
    logic [fid_pkg::THR_SQ_W-1:0]  cfg_thr_sq;

    assign cfg_thr    = cfg_wr_data[fid_pkg::THR_W-1:0];
    assign cfg_thr_sq = fid_pkg::THR_SQ_W'(cfg_thr) * fid_pkg::THR_SQ_W'(cfg_thr);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            impact_sq_reg <= fid_pkg::IMPACT_SQ_RST;
            angle_thr_reg <= fid_pkg::ANGLE_RST;
            immobile_reg  <= fid_pkg::IMMOBILE_RST;
            still_sq_reg  <= fid_pkg::STILL_SQ_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                fid_pkg::CFG_IMPACT:   impact_sq_reg <= cfg_thr_sq;
                fid_pkg::CFG_ANGLE:    angle_thr_reg <= cfg_wr_data[fid_pkg::CHANGE_W-1:0];
                fid_pkg::CFG_IMMOBILE: immobile_reg  <= cfg_wr_data[fid_pkg::WAIT_W-1:0];
                fid_pkg::CFG_STILL:    still_sq_reg  <= cfg_thr_sq;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage handshakes
    logic v1_reg, m_valid_reg;
    logic adv2, rdy1, fire2;

    // each stage moves on when it is empty or the one after it moves
    assign adv2    = !m_valid_reg || m_ready;
    assign rdy1    = !v1_reg || adv2;
    // no word is taken while reset is held
    assign s_ready = rdy1 && aresetn;
    assign fire2   = v1_reg && adv2;

    // ---------------------------------------------------------------- stage 1: input register
    logic                                kind1_reg;
    logic signed [fid_pkg::ACCEL_W-1:0]  ax1_reg, ay1_reg, az1_reg;
    logic signed [fid_pkg::ANGLE_W-1:0]  pitch1_reg, roll1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            kind1_reg  <= s_kind;
            ax1_reg    <= s_accel_x;
            ay1_reg    <= s_accel_y;
            az1_reg    <= s_accel_z;
            pitch1_reg <= s_pitch_angle;
            roll1_reg  <= s_roll_angle;
        end
    end

    // ---------------------------------------------------------------- squared magnitude
    // magnitude of a 16-bit signed value fits 16 unsigned bits, -32768 included
    logic [fid_pkg::ACCEL_W-1:0] abs_x, abs_y, abs_z;
    logic [fid_pkg::MAG_W-1:0]   sq_x, sq_y, sq_z, mag_sum;

    assign abs_x   = ax1_reg[fid_pkg::ACCEL_W-1] ? fid_pkg::ACCEL_W'(-ax1_reg) : ax1_reg;
    assign abs_y   = ay1_reg[fid_pkg::ACCEL_W-1] ? fid_pkg::ACCEL_W'(-ay1_reg) : ay1_reg;
    assign abs_z   = az1_reg[fid_pkg::ACCEL_W-1] ? fid_pkg::ACCEL_W'(-az1_reg) : az1_reg;
    assign sq_x    = fid_pkg::MAG_W'(abs_x) * fid_pkg::MAG_W'(abs_x);
    assign sq_y    = fid_pkg::MAG_W'(abs_y) * fid_pkg::MAG_W'(abs_y);
    assign sq_z    = fid_pkg::MAG_W'(abs_z) * fid_pkg::MAG_W'(abs_z);
    // at most 3 * 2^30, no overflow
    assign mag_sum = sq_x + sq_y + sq_z;

    // ---------------------------------------------------------------- stage 2: detector state
    logic [fid_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic signed [fid_pkg::ANGLE_W-1:0]  prev_pitch_reg, prev_pitch_next;
    logic signed [fid_pkg::ANGLE_W-1:0]  prev_roll_reg, prev_roll_next;
    logic [fid_pkg::WAIT_W-1:0]          wait_count_reg, wait_count_next;
    logic [fid_pkg::MAG_W-1:0]           held_mag_reg, held_mag_next;
    logic [fid_pkg::CHANGE_W-1:0]        held_angle_reg, held_angle_next;
    logic [fid_pkg::TIME_WIDTH-1:0]      uptime_reg, uptime_next;

    // angle change: sign-extended differences, each magnitude at most 32767
    logic signed [fid_pkg::CHANGE_W-1:0] d_pitch, d_roll;
    logic [fid_pkg::CHANGE_W-1:0]        abs_d_pitch, abs_d_roll, change;
    logic                                impact_hit, angle_hit, is_still;
    logic                                emit;

    assign d_pitch     = {pitch1_reg[fid_pkg::ANGLE_W-1], pitch1_reg}
                       - {prev_pitch_reg[fid_pkg::ANGLE_W-1], prev_pitch_reg};
    assign d_roll      = {roll1_reg[fid_pkg::ANGLE_W-1], roll1_reg}
                       - {prev_roll_reg[fid_pkg::ANGLE_W-1], prev_roll_reg};
    assign abs_d_pitch = d_pitch[fid_pkg::CHANGE_W-1] ? fid_pkg::CHANGE_W'(-d_pitch) : d_pitch;
    assign abs_d_roll  = d_roll[fid_pkg::CHANGE_W-1] ? fid_pkg::CHANGE_W'(-d_roll) : d_roll;
    assign change      = abs_d_pitch + abs_d_roll;

    assign impact_hit  = mag_sum >= fid_pkg::MAG_W'(impact_sq_reg);
    assign angle_hit   = change >= angle_thr_reg;
    assign is_still    = mag_sum <= fid_pkg::MAG_W'(still_sq_reg);

    always_comb begin
        phase_next      = phase_reg;
        prev_pitch_next = prev_pitch_reg;
        prev_roll_next  = prev_roll_reg;
        wait_count_next = wait_count_reg;
        held_mag_next   = held_mag_reg;
        held_angle_next = held_angle_reg;
        uptime_next     = uptime_reg;
        emit            = 1'b0;
        if (fire2) begin
            if (kind1_reg == fid_pkg::KIND_TICK) begin
                // uptime wraps at its width
                uptime_next = uptime_reg + fid_pkg::TIME_WIDTH'(1);
                if (phase_reg == fid_pkg::PH_WAIT) begin
                    wait_count_next = wait_count_reg + fid_pkg::WAIT_W'(1);
                    // a lowered immobile_ms ends the wait at the next tick
                    if (wait_count_next >= immobile_reg) begin
                        phase_next = fid_pkg::PH_CHECK;
                    end
                end
            end else begin
                unique case (phase_reg)
                    fid_pkg::PH_WAIT: begin
                        // samples during the wait are dropped
                    end
                    fid_pkg::PH_CHECK: begin
                        // stillness sample: verdict out, orientation not stored
                        emit       = 1'b1;
                        phase_next = fid_pkg::PH_IDLE;
                    end
                    default: begin
                        // idle, and the unused code behaves as idle
                        prev_pitch_next = pitch1_reg;
                        prev_roll_next  = roll1_reg;
                        if (impact_hit && angle_hit) begin
                            held_mag_next   = mag_sum;
                            held_angle_next = change;
                            wait_count_next = '0;
                            phase_next      = (immobile_reg == '0) ? fid_pkg::PH_CHECK
                                                                   : fid_pkg::PH_WAIT;
                        end else begin
                            phase_next = fid_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= fid_pkg::PH_IDLE;
            prev_pitch_reg <= '0;
            prev_roll_reg  <= '0;
            wait_count_reg <= '0;
            held_mag_reg   <= '0;
            held_angle_reg <= '0;
            uptime_reg     <= '0;
        end else begin
            phase_reg      <= phase_next;
            prev_pitch_reg <= prev_pitch_next;
            prev_roll_reg  <= prev_roll_next;
            wait_count_reg <= wait_count_next;
            held_mag_reg   <= held_mag_next;
            held_angle_reg <= held_angle_next;
            uptime_reg     <= uptime_next;
        end
    end

    // ---------------------------------------------------------------- result register
    logic                            confirm_reg;
    logic [fid_pkg::EVT_W-1:0]       evt_time_reg;
    logic [fid_pkg::MAG_W-1:0]       out_mag_reg;
    logic [fid_pkg::CHANGE_W-1:0]    out_angle_reg;

    // a result only loads when the register is free or being emptied (fire2 implies adv2)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            confirm_reg   <= is_still;
            // low bits of the uptime, zero-extended if the counter is narrower
            evt_time_reg  <= fid_pkg::EVT_W'(uptime_reg);
            out_mag_reg   <= held_mag_reg;
            out_angle_reg <= held_angle_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_fall_confirmed      = confirm_reg;
    assign m_event_time_ms       = evt_time_reg;
    assign m_impact_magnitude_sq = out_mag_reg;
    assign m_orient_delta        = out_angle_reg;

endmodule

FILE: hdl/fid_checker.sv
// fid_checker: port-level assertions for the fall impact detector, bound to the top level
// depends on fid_pkg and fall_impact_detector
module fid_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_fall_confirmed,
    input logic [fid_pkg::EVT_W-1:0]          m_event_time_ms,
    input logic [fid_pkg::MAG_W-1:0]          m_impact_magnitude_sq,
    input logic [fid_pkg::CHANGE_W-1:0]       m_orient_delta
);

    // a held result word keeps its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fall_confirmed)
            && $stable(m_event_time_ms) && $stable(m_impact_magnitude_sq)
            && $stable(m_orient_delta))
        else $error("result word changed while stalled");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // squared magnitude of three 16-bit values cannot exceed 3 * 2^30
    a_mag_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_impact_magnitude_sq <= fid_pkg::MAG_MAX)
        else $error("impact magnitude out of range");

    // two 15-bit angle differences sum to at most 65534
    a_angle_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_orient_delta <= fid_pkg::CHANGE_MAX)
        else $error("orientation change out of range");

endmodule

bind fall_impact_detector fid_checker u_fid_checker (
    .aclk                  (aclk),
    .aresetn               (aresetn),
    .m_valid               (m_valid),
    .m_ready               (m_ready),
    .m_fall_confirmed      (m_fall_confirmed),
    .m_event_time_ms       (m_event_time_ms),
    .m_impact_magnitude_sq (m_impact_magnitude_sq),
    .m_orient_delta        (m_orient_delta)
);

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for fall_impact_detector, driven with directed and random words
// depends on fid_pkg and fall_impact_detector; carries its own model of the detector
module testbench;
    import fid_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 6;
    // cycles let pass after the last verdict before the block counts as idle
    localparam int DRAIN_CYCLES = 8;
    // cycles without any accepted word before the run is given up
    localparam int STUCK_LIMIT  = 4000;
    localparam int PHASE_WORDS  = 95;
    localparam int RANDOM_PHASES = 10;
    // wait used by the long wait test
    localparam int LONG_WAIT    = 100;

    typedef struct packed {
        logic                      kind;
        logic signed [ACCEL_W-1:0] ax;
        logic signed [ACCEL_W-1:0] ay;
        logic signed [ACCEL_W-1:0] az;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [ANGLE_W-1:0] roll;
    } imu_word_t;

    typedef struct packed {
        logic                fall;
        logic [EVT_W-1:0]    event_time;
        logic [MAG_W-1:0]    magnitude_sq;
        logic [CHANGE_W-1:0] change;
    } verdict_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic                      s_kind        = KIND_SAMPLE;
    logic signed [ACCEL_W-1:0] s_accel_x     = '0;
    logic signed [ACCEL_W-1:0] s_accel_y     = '0;
    logic signed [ACCEL_W-1:0] s_accel_z     = '0;
    logic signed [ANGLE_W-1:0] s_pitch_angle = '0;
    logic signed [ANGLE_W-1:0] s_roll_angle  = '0;

    logic                m_valid;
    logic                m_ready = 1'b0;
    logic                m_fall_confirmed;
    logic [EVT_W-1:0]    m_event_time_ms;
    logic [MAG_W-1:0]    m_impact_magnitude_sq;
    logic [CHANGE_W-1:0] m_orient_delta;

    fall_impact_detector dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wr_data           (cfg_wr_data),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_kind                (s_kind),
        .s_accel_x             (s_accel_x),
        .s_accel_y             (s_accel_y),
        .s_accel_z             (s_accel_z),
        .s_pitch_angle         (s_pitch_angle),
        .s_roll_angle          (s_roll_angle),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_fall_confirmed      (m_fall_confirmed),
        .m_event_time_ms       (m_event_time_ms),
        .m_impact_magnitude_sq (m_impact_magnitude_sq),
        .m_orient_delta        (m_orient_delta)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------
    // detector model: its own copy of the registers and the state
    // ------------------------------------------------------------------
    logic [THR_W-1:0]          reg_impact   = IMPACT_RST;
    logic [CHANGE_W-1:0]       reg_angle    = ANGLE_RST;
    logic [WAIT_W-1:0]         reg_immobile = IMMOBILE_RST;
    logic [THR_W-1:0]          reg_still    = STILL_RST;

    logic signed [ANGLE_W-1:0] prev_pitch   = '0;
    logic signed [ANGLE_W-1:0] prev_roll    = '0;
    logic [PHASE_W-1:0]        det_phase    = PH_IDLE;
    logic [WAIT_W-1:0]         wait_count   = '0;
    logic [MAG_W-1:0]          held_mag_sq  = '0;
    logic [CHANGE_W-1:0]       held_turn    = '0;
    logic [TIME_WIDTH-1:0]     uptime_now   = '0;

    verdict_t  verdicts_due[$];
    imu_word_t words_to_send[$];

    // exact squared magnitude, no square root needed
    function automatic logic [MAG_W-1:0] magnitude_sq(input imu_word_t w);
        longint x;
        longint y;
        longint z;
        x = longint'($signed(w.ax));
        y = longint'($signed(w.ay));
        z = longint'($signed(w.az));
        return MAG_W'(x * x + y * y + z * z);
    endfunction

    // summed absolute pitch and roll change against the stored orientation
    function automatic int orientation_turn(input imu_word_t w);
        int dp;
        int dr;
        dp = int'($signed(w.pitch)) - int'(prev_pitch);
        dr = int'($signed(w.roll)) - int'(prev_roll);
        if (dp < 0) dp = -dp;
        if (dr < 0) dr = -dr;
        return dp + dr;
    endfunction

    task automatic predict_verdict(input imu_word_t w);
        verdict_t         v;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] limit_sq;
        int               turn;
        if (w.kind == KIND_TICK) begin
            // every tick moves the uptime, the wait only counts in the waiting phase
            uptime_now = uptime_now + 1'b1;
            if (det_phase == PH_WAIT) begin
                wait_count = wait_count + 1'b1;
                if (wait_count >= reg_immobile) det_phase = PH_CHECK;
            end
        end else if (det_phase == PH_WAIT) begin
            // samples during the wait are dropped, orientation untouched
        end else if (det_phase == PH_CHECK) begin
            mag      = magnitude_sq(w);
            limit_sq = MAG_W'(reg_still) * MAG_W'(reg_still);
            v.fall         = (mag <= limit_sq);
            v.event_time   = EVT_W'(uptime_now);
            v.magnitude_sq = held_mag_sq;
            v.change       = held_turn;
            verdicts_due.push_back(v);
            det_phase = PH_IDLE;
        end else begin
            mag        = magnitude_sq(w);
            limit_sq   = MAG_W'(reg_impact) * MAG_W'(reg_impact);
            turn       = orientation_turn(w);
            prev_pitch = w.pitch;
            prev_roll  = w.roll;
            if (mag >= limit_sq && turn >= int'(reg_angle)) begin
                held_mag_sq = mag;
                held_turn   = CHANGE_W'(turn);
                wait_count  = '0;
                det_phase   = (reg_immobile == '0) ? PH_CHECK : PH_WAIT;
            end else begin
                det_phase = PH_IDLE;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // checking, prediction and watchdog, all at the rising edge
    // ------------------------------------------------------------------
    int mismatches     = 0;
    int accepted_words = 0;
    int stuck_cycles   = 0;
    bit in_fired       = 1'b0;

    always @(posedge aclk) begin
        verdict_t  due;
        imu_word_t w;
        // result side first, so an expectation is never consumed by its own word
        if (m_valid === 1'b1 && m_ready) begin
            if (verdicts_due.size() == 0) begin
                $error("result word with no verdict due");
                mismatches++;
            end else begin
                due = verdicts_due.pop_front();
                if (m_fall_confirmed !== due.fall) begin
                    $error("fall_confirmed: expected %0d, actual %0d", due.fall, m_fall_confirmed);
                    mismatches++;
                end
                if (m_event_time_ms !== due.event_time) begin
                    $error("event_time_ms: expected %0d, actual %0d",
                           due.event_time, m_event_time_ms);
                    mismatches++;
                end
                if (m_impact_magnitude_sq !== due.magnitude_sq) begin
                    $error("impact_magnitude_sq: expected %0d, actual %0d",
                           due.magnitude_sq, m_impact_magnitude_sq);
                    mismatches++;
                end
                if (m_orient_delta !== due.change) begin
                    $error("orient_delta: expected %0d, actual %0d", due.change, m_orient_delta);
                    mismatches++;
                end
            end
        end

        // register writes, masked to their widths
        if (aresetn && cfg_wr_en) begin
            case (cfg_index)
                CFG_IMPACT:   reg_impact   = cfg_wr_data[THR_W-1:0];
                CFG_ANGLE:    reg_angle    = cfg_wr_data[CHANGE_W-1:0];
                CFG_IMMOBILE: reg_immobile = cfg_wr_data[WAIT_W-1:0];
                CFG_STILL:    reg_still    = cfg_wr_data[THR_W-1:0];
                default: ;
            endcase
        end

        if (aresetn && s_valid && s_ready) begin
            w.kind  = s_kind;
            w.ax    = s_accel_x;
            w.ay    = s_accel_y;
            w.az    = s_accel_z;
            w.pitch = s_pitch_angle;
            w.roll  = s_roll_angle;
            predict_verdict(w);
            accepted_words <= accepted_words + 1;
        end
        in_fired <= aresetn && s_valid && s_ready;

        // watchdog: any handshake or register write counts as progress
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid === 1'b1 && m_ready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // driver: bursts of words with random gaps, fed from words_to_send
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge aclk) begin
        imu_word_t w;
        // a word on offer stays put until taken
        if (!s_valid || in_fired) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (words_to_send.size() != 0) begin
                w = words_to_send.pop_front();
                s_valid       <= 1'b1;
                s_kind        <= w.kind;
                s_accel_x     <= w.ax;
                s_accel_y     <= w.ay;
                s_accel_z     <= w.az;
                s_pitch_angle <= w.pitch;
                s_roll_angle  <= w.roll;
                burst_left--;
                if (burst_left <= 0) begin
                    // now and then a long stretch with no gaps at all
                    if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(50, 200);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(1, 12);
                    end
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready pattern switches between a few modes
    // ------------------------------------------------------------------
    int ready_mode = 0;
    int mode_left  = 0;
    int stall_left = 0;
    int ready_tick = 0;

    always @(negedge aclk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
        end
        mode_left--;
        ready_tick++;
        case (ready_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= ((ready_tick % 4) == 3);
            default: begin
                // long stalls now and then
                if (stall_left > 0) begin
                    stall_left--;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int pushed_words = 0;
    int phase_words  = 0;
    int plan_impact   = IMPACT_RST;
    int plan_angle    = ANGLE_RST;
    int plan_immobile = IMMOBILE_RST;
    int plan_still    = STILL_RST;

    // counted is clear for samples the block is only meant to drop
    task automatic push_word(input logic kind, input int ax, input int ay, input int az,
                             input int pitch, input int roll, input bit counted);
        imu_word_t w;
        w.kind  = kind;
        w.ax    = ACCEL_W'(ax);
        w.ay    = ACCEL_W'(ay);
        w.az    = ACCEL_W'(az);
        w.pitch = ANGLE_W'(pitch);
        w.roll  = ANGLE_W'(roll);
        words_to_send.push_back(w);
        pushed_words++;
        if (counted) phase_words++;
    endtask

    task automatic push_sample(input int ax, input int ay, input int az,
                               input int pitch, input int roll);
        push_word(KIND_SAMPLE, ax, ay, az, pitch, roll, 1'b1);
    endtask

    // tick fields carry junk on purpose, only kind matters
    task automatic push_tick();
        push_word(KIND_TICK, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
    endtask

    task automatic push_noise();
        push_word($urandom_range(0, 1) ? KIND_TICK : KIND_SAMPLE,
                  $urandom, $urandom, $urandom, $urandom, $urandom, 1'b1);
    endtask

    // wait until every word is taken and every verdict has come, then let the pipe empty
    task automatic settle();
        do @(negedge aclk);
        while (accepted_words != pushed_words || verdicts_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // all four registers in a row; bit 15 is junk for the 15-bit ones
    task automatic write_regs(input int impact, input int angle, input int immobile,
                              input int still);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_IMPACT;
        cfg_wr_data <= {$urandom_range(0, 1) == 1, THR_W'(impact)};
        @(negedge aclk);
        cfg_index   <= CFG_ANGLE;
        cfg_wr_data <= CFG_DATA_W'(angle);
        @(negedge aclk);
        cfg_index   <= CFG_IMMOBILE;
        cfg_wr_data <= CFG_DATA_W'(immobile);
        @(negedge aclk);
        cfg_index   <= CFG_STILL;
        cfg_wr_data <= {$urandom_range(0, 1) == 1, THR_W'(still)};
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        plan_impact   = impact & 32'h7FFF;
        plan_angle    = angle & 32'hFFFF;
        plan_immobile = immobile & 32'hFFFF;
        plan_still    = still & 32'h7FFF;
        // pushes start at a rising edge so the driver picks them up cleanly
        @(posedge aclk);
    endtask

    // orientation sample, impact, wait with dropped samples, stillness sample
    task automatic push_fall_sequence();
        int target;
        int dp;
        int dr;
        int p0;
        int p1;
        int r0;
        int r1;
        int t;
        int amp;
        int axis;
        int n_ticks;
        int acc[3];
        if (plan_angle > 65534)
            target = 65534;
        else if ($urandom_range(0, 4) == 0)
            target = plan_angle;
        else
            target = $urandom_range(plan_angle,
                                    (plan_angle + 8000 > 65534) ? 65534 : plan_angle + 8000);
        // split the turn between pitch and roll, both within the 15-bit range
        dp = $urandom_range(target > 32767 ? target - 32767 : 0, target < 32767 ? target : 32767);
        dr = target - dp;
        p0 = $urandom_range(0, 32767 - dp) - 16384;
        p1 = p0 + dp;
        r0 = $urandom_range(0, 32767 - dr) - 16384;
        r1 = r0 + dr;
        if ($urandom_range(0, 1)) begin t = p0; p0 = p1; p1 = t; end
        if ($urandom_range(0, 1)) begin t = r0; r0 = r1; r1 = t; end
        push_sample($urandom_range(0, 255) - 128, $urandom_range(0, 255) - 128,
                    $urandom_range(0, 255) - 128, p0, r0);

        // impact, sometimes exactly on the threshold
        amp  = ($urandom_range(0, 4) == 0) ? plan_impact : $urandom_range(plan_impact, 32767);
        axis = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) acc[i] = $urandom_range(0, 1) ? 0 : int'($urandom);
        acc[axis] = $urandom_range(0, 1) ? -amp : amp;
        if (amp == 32767 && $urandom_range(0, 3) == 0) acc[axis] = -32768;
        push_sample(acc[0], acc[1], acc[2], p1, r1);

        // wait, now and then one tick short so the check sample is dropped
        n_ticks = plan_immobile + $urandom_range(0, 2);
        if (plan_immobile > 0 && $urandom_range(0, 7) == 0) n_ticks = plan_immobile - 1;
        repeat (n_ticks) begin
            if ($urandom_range(0, 4) == 0)
                push_word(KIND_SAMPLE, $urandom, $urandom, $urandom, $urandom, $urandom, 1'b0);
            push_tick();
        end

        // stillness sample: well inside, on the limit or one past it, or anything
        for (int i = 0; i < 3; i++) acc[i] = 0;
        case ($urandom_range(0, 4))
            0, 1: begin
                for (int i = 0; i < 3; i++) begin
                    acc[i] = $urandom_range(0, plan_still / 2);
                    if ($urandom_range(0, 1)) acc[i] = -acc[i];
                end
            end
            2: begin
                amp = plan_still + $urandom_range(0, 1);
                acc[$urandom_range(0, 2)] = (amp == 32768 || $urandom_range(0, 1)) ? -amp : amp;
            end
            default: begin
                for (int i = 0; i < 3; i++) acc[i] = $urandom;
            end
        endcase
        push_sample(acc[0], acc[1], acc[2], $urandom, $urandom);
    endtask

    initial begin
        bit paused;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed part ---
        write_regs(IMPACT_RST, ANGLE_RST, 3, STILL_RST);
        push_sample(0, 0, 0, 0, 0);
        // largest magnitude with a big turn: impact
        push_sample(-32768, -32768, -32768, -16384, 16383);
        push_tick();
        // dropped while waiting, its orientation must not stick
        push_sample(32767, 32767, 32767, 16383, -16384);
        push_tick();
        push_tick();
        // stillness check: a fall, uptime 3
        push_sample(0, 0, 0, 5, 5);
        // magnitude on the impact threshold, largest possible turn
        push_sample(5120, 0, 0, 16383, -16384);
        repeat (3) push_tick();
        // one past the still limit: false alarm
        push_sample(513, 0, 0, 0, 0);
        // turn exactly on the angle threshold
        push_sample(0, -5120, 0, 16383 - 2880, -16384);
        push_tick();
        // lower the wait while the block is waiting
        settle();
        write_regs(IMPACT_RST, ANGLE_RST, 1, STILL_RST);
        push_tick();
        push_sample(0, 0, 512, 0, 0);
        // just below each threshold: no impact
        push_sample(5119, 0, 0, 0, 0);
        push_sample(5120, 0, 0, 2879, 0);
        // zero wait: impact goes straight to the check
        settle();
        write_regs(IMPACT_RST, ANGLE_RST, 0, STILL_RST);
        push_sample(32767, 0, 0, -8000, 0);
        push_sample(-32768, 32767, 0, 0, 0);
        push_tick();
        // all registers at zero: every sample is an impact, only zero is still
        settle();
        write_regs(0, 0, 0, 0);
        push_sample($urandom, $urandom, $urandom, $urandom, $urandom);
        push_sample(0, 0, 0, 0, 0);
        push_sample(1, 0, 0, 0, 0);
        push_sample(0, 0, 1, 0, 0);

        // long wait, with a check sample one tick too early
        settle();
        write_regs(IMPACT_RST, ANGLE_RST, LONG_WAIT, 32767);
        push_sample(0, 0, 0, 0, 0);
        push_sample(-32768, 0, 0, 11520, -11520);
        for (int i = 1; i < LONG_WAIT; i++) begin
            if (i % 32 == 0) push_word(KIND_SAMPLE, 0, 0, 0, 1000, 1000, 1'b0);
            push_tick();
        end
        push_word(KIND_SAMPLE, 0, 0, 0, 0, 0, 1'b0);
        push_tick();
        push_sample(32767, 0, 0, 0, 0);

        // --- random part, one register setting per phase ---
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            case (ph)
                0: write_regs(IMPACT_RST, ANGLE_RST, $urandom_range(0, 6), STILL_RST);
                1: write_regs(0, 0, $urandom_range(0, 3), 0);
                2: write_regs(32767, 46080, $urandom_range(1, 8), 32767);
                3: write_regs($urandom_range(0, 8000), 65535, $urandom_range(0, 4),
                              $urandom_range(0, 32767));
                default: write_regs($urandom_range(0, 12000), $urandom_range(0, 46080),
                                    $urandom_range(0, 8), $urandom_range(0, 32767));
            endcase
            phase_words = 0;
            paused      = 1'b0;
            while (phase_words < PHASE_WORDS) begin
                // half way through, hold the sender until all verdicts are in
                if (!paused && phase_words >= PHASE_WORDS / 2) begin
                    settle();
                    @(posedge aclk);
                    paused = 1'b1;
                end
                if ($urandom_range(0, 3) != 0)
                    push_fall_sequence();
                else
                    repeat ($urandom_range(1, 4)) push_noise();
            end
        end

        settle();
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
